// File: design/jcl_pkg.sv
// shared constants, codes and types of the joystick combination lock
package jcl_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int CODE_LENGTH = 4;
    localparam int POS_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int SYM_W       = 3;
    localparam int SEG_W       = 7;
    localparam int LED_W       = 2;
    localparam int ACT_W       = 2;
    localparam int CFG_IDX_W   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_LOW  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MIN     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MAX     = 8'd3;

    localparam logic [SAMPLE_BITS-1:0] RST_DIRECTION_HIGH = SAMPLE_BITS'(615);
    localparam logic [SAMPLE_BITS-1:0] RST_DIRECTION_LOW  = SAMPLE_BITS'(409);
    localparam logic [SAMPLE_BITS-1:0] RST_CENTER_MIN     = SAMPLE_BITS'(308);
    localparam logic [SAMPLE_BITS-1:0] RST_CENTER_MAX     = SAMPLE_BITS'(614);

    // direction symbols
    localparam logic [SYM_W-1:0] SYM_NONE  = 3'd0;
    localparam logic [SYM_W-1:0] SYM_UP    = 3'd1;
    localparam logic [SYM_W-1:0] SYM_DOWN  = 3'd2;
    localparam logic [SYM_W-1:0] SYM_LEFT  = 3'd3;
    localparam logic [SYM_W-1:0] SYM_RIGHT = 3'd4;

    // seven-segment patterns
    localparam logic [SEG_W-1:0] SEG_CENTER = 7'b0000001;
    localparam logic [SEG_W-1:0] SEG_YHIGH  = 7'b0000101;
    localparam logic [SEG_W-1:0] SEG_YLOW   = 7'b0110000;
    localparam logic [SEG_W-1:0] SEG_XLOW   = 7'b0111101;
    localparam logic [SEG_W-1:0] SEG_XHIGH  = 7'b0011100;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CW    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CCW   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_BLINK = 2'd3;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic             dir_valid;
        logic [SYM_W-1:0] dir;
        logic             centered;
    } t_class;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [LED_W-1:0] led;
        logic             point;
        logic [ACT_W-1:0] action;
    } t_result;

endpackage

// File: design/jcl_classify.sv
// threshold registers and joystick direction / center classification
module jcl_classify
    import jcl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_sample              i_cfg_data,
    input  t_sample              i_x_sample,
    input  t_sample              i_y_sample,
    output t_class               o_class
);

    t_sample r_dir_high;
    t_sample r_dir_low;
    t_sample r_ctr_min;
    t_sample r_ctr_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_high <= RST_DIRECTION_HIGH;
            r_dir_low  <= RST_DIRECTION_LOW;
            r_ctr_min  <= RST_CENTER_MIN;
            r_ctr_max  <= RST_CENTER_MAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIRECTION_HIGH: r_dir_high <= i_cfg_data;
                CFG_DIRECTION_LOW:  r_dir_low  <= i_cfg_data;
                CFG_CENTER_MIN:     r_ctr_min  <= i_cfg_data;
                CFG_CENTER_MAX:     r_ctr_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic x_in_win;
    logic y_in_win;

    assign x_in_win = (i_x_sample >= r_ctr_min) && (i_x_sample <= r_ctr_max);
    assign y_in_win = (i_y_sample >= r_ctr_min) && (i_y_sample <= r_ctr_max);

    always_comb begin
        o_class.centered  = x_in_win && y_in_win;
        o_class.dir_valid = 1'b1;
        o_class.dir       = SYM_NONE;
        o_class.seg       = SEG_CENTER;
        // y axis wins over x axis, high side over low side
        if (i_y_sample >= r_dir_high) begin
            o_class.seg = SEG_YHIGH;
            o_class.dir = SYM_RIGHT;
        end else if (i_y_sample <= r_dir_low) begin
            o_class.seg = SEG_YLOW;
            o_class.dir = SYM_LEFT;
        end else if (i_x_sample >= r_dir_high) begin
            o_class.seg = SEG_XHIGH;
            o_class.dir = SYM_UP;
        end else if (i_x_sample <= r_dir_low) begin
            o_class.seg = SEG_XLOW;
            o_class.dir = SYM_DOWN;
        end else begin
            o_class.dir_valid = 1'b0;
        end
    end

endmodule

// File: design/jcl_lock.sv
// lock state machine: entry, code compare, overwrite and led/point registers
module jcl_lock
    import jcl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_class  i_class,
    input  logic    i_button_pin,
    output t_result o_result
);

    localparam logic [1:0] MODE_WAIT      = 2'd0;
    localparam logic [1:0] MODE_PRESS     = 2'd1;
    localparam logic [1:0] MODE_OVERWRITE = 2'd2;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CODE_LENGTH - 1);

    logic [1:0]       r_mode,   n_mode;
    logic [POS_W-1:0] r_entry,  n_entry;
    logic [SYM_W-1:0] r_entered [CODE_LENGTH];
    logic [SYM_W-1:0] n_entered [CODE_LENGTH];
    logic [SYM_W-1:0] r_code    [CODE_LENGTH];
    logic [SYM_W-1:0] n_code    [CODE_LENGTH];
    logic [SYM_W-1:0] r_last,   n_last;
    logic             r_parity, n_parity;
    logic             r_ow,     n_ow;
    logic [LED_W-1:0] r_led,    n_led;
    logic             r_point,  n_point;

    always_comb begin
        logic skip;
        logic match;
        n_mode   = r_mode;
        n_entry  = r_entry;
        n_entered = r_entered;
        n_code   = r_code;
        n_last   = i_class.dir_valid ? i_class.dir : r_last;
        n_parity = r_parity;
        n_ow     = r_ow;
        n_led    = r_led;
        n_point  = r_point;
        o_result.seg    = i_class.seg;
        o_result.action = ACT_NONE;
        skip  = 1'b0;
        match = 1'b1;

        case (r_mode)
            MODE_WAIT: begin
                if (!i_class.centered) begin
                    n_mode = MODE_PRESS;
                end else if (!i_button_pin && r_parity) begin
                    n_mode = MODE_OVERWRITE;
                end
            end
            MODE_OVERWRITE: begin
                if (i_button_pin) begin
                    n_mode = MODE_WAIT;
                end
            end
            MODE_PRESS: begin
                if (i_class.centered) begin
                    n_entered[r_entry] = n_last;
                    if (r_ow) begin
                        n_code[r_entry] = n_last;
                    end
                    if (r_entry == POS_LAST) begin
                        n_entry      = '0;
                        o_result.seg = SEG_CENTER;
                        for (int i = 0; i < CODE_LENGTH; i++) begin
                            match = match && (n_entered[i] == n_code[i]);
                        end
                        if (match) begin
                            n_parity = ~r_parity;
                            n_ow     = 1'b0;
                            n_point  = 1'b0;
                            o_result.action = n_parity ? ACT_CW : ACT_CCW;
                        end else begin
                            o_result.action = ACT_BLINK;
                            n_led = '1;
                        end
                        skip = 1'b1;
                    end else begin
                        n_entry = r_entry + 1'b1;
                    end
                    n_mode = MODE_WAIT;
                end
            end
            default: n_mode = MODE_WAIT;
        endcase

        if (!skip) begin
            if (n_mode == MODE_WAIT) begin
                n_led = LED_W'(n_entry);
            end else if (n_mode == MODE_OVERWRITE) begin
                n_entry = '0;
                n_ow    = 1'b1;
                n_point = 1'b1;
            end
        end

        o_result.led   = n_led;
        o_result.point = n_point;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_WAIT;
            r_entry  <= '0;
            r_last   <= SYM_NONE;
            r_parity <= 1'b0;
            r_ow     <= 1'b0;
            r_led    <= '0;
            r_point  <= 1'b0;
            for (int i = 0; i < CODE_LENGTH; i++) begin
                r_entered[i] <= SYM_NONE;
                r_code[i]    <= SYM_W'((i % 4) + 1);
            end
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_entry   <= n_entry;
            r_entered <= n_entered;
            r_code    <= n_code;
            r_last    <= n_last;
            r_parity  <= n_parity;
            r_ow      <= n_ow;
            r_led     <= n_led;
            r_point   <= n_point;
        end
    end

    // point lamp mirrors the armed overwrite flag
    a_point_ow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_point == r_ow)
        else $error("point register differs from overwrite flag");

    a_ow_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_OVERWRITE) |-> (r_entry == '0))
        else $error("entry position not cleared in overwrite mode");

    a_rot_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (o_result.action == ACT_CW || o_result.action == ACT_CCW))
        |=> (r_parity != $past(r_parity)) && (r_entry == '0))
        else $error("rotation without parity toggle and entry reset");

    a_blink_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.action == ACT_BLINK) |=> (r_led == '1)
            && (r_parity == $past(r_parity)))
        else $error("error blink left wrong led or parity");

endmodule

// File: design/joystick_combination_lock.sv
// top level of the joystick combination lock: handshakes and result register
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_x_sample, i_y_sample, i_button_pin
//  out     | out       | o_out_valid / i_out_ready  | o_segments, o_led_value,
//          |           |                            | o_decimal_point, o_action
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one beat in gives one beat out, in the cycle after it is taken, from the result register
// a new beat is taken every cycle as long as the result register is empty or drained
// the same cycle; the classify and lock step fit between state and result register
// synchronous active-low reset clears thresholds, lock state and the output valid
// cfg writes are taken every cycle; out-of-range indexes are ignored
module joystick_combination_lock
    import jcl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_x_sample,
    input  logic [SAMPLE_BITS-1:0] i_y_sample,
    input  logic                 i_button_pin,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SEG_W-1:0]     o_segments,
    output logic [LED_W-1:0]     o_led_value,
    output logic                 o_decimal_point,
    output logic [ACT_W-1:0]     o_action,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data
);

    t_class  cls;
    t_result res;
    logic    accept;

    logic    r_out_valid;
    t_result r_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    jcl_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_x_sample  (i_x_sample),
        .i_y_sample  (i_y_sample),
        .o_class     (cls)
    );

    jcl_lock u_lock (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_class      (cls),
        .i_button_pin (i_button_pin),
        .o_result     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_segments      = r_res.seg;
    assign o_led_value     = r_res.led;
    assign o_decimal_point = r_res.point;
    assign o_action        = r_res.action;

endmodule

// File: tb/joystick_combination_lock_test.sv
// self-checking testbench of the joystick combination lock, with its own lock predictor
module joystick_combination_lock_test;
    import jcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [SYM_W-1:0] t_sym;
    typedef enum logic [1:0] {LOCK_WAIT, LOCK_PRESS, LOCK_OVERWRITE} t_lock_mode;

    localparam int     IDLE_PCT       = 34;
    localparam int     SETTLE_CYCLES  = 4;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     RANDOM_TICKS   = 1000;
    localparam int     MAX_PRINTS     = 40;
    localparam int     SAMPLE_TOP     = (1 << SAMPLE_BITS) - 1;
    localparam t_sample SAMPLE_MAX    = '1;
    localparam t_sample MID           = SAMPLE_BITS'(512);
    localparam logic   BTN_PRESSED    = 1'b0;
    localparam logic   BTN_RELEASED   = 1'b1;
    localparam logic [CODE_LENGTH*SYM_W-1:0] RESET_CODE =
        {SYM_RIGHT, SYM_LEFT, SYM_DOWN, SYM_UP};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_sample              i_x_sample;
    t_sample              i_y_sample;
    logic                 i_button_pin;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [SEG_W-1:0]     o_segments;
    logic [LED_W-1:0]     o_led_value;
    logic                 o_decimal_point;
    logic [ACT_W-1:0]     o_action;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_sample              i_cfg_data;

    // predicted lock state and thresholds
    t_sample          thr_high, thr_low, win_min, win_max;
    t_lock_mode       lock_mode;
    logic [POS_W-1:0] entry_pos;
    t_sym             entered_syms [CODE_LENGTH];
    t_sym             code_syms [CODE_LENGTH];
    t_sym             last_sym;
    logic             unlock_odd;
    logic             overwrite_armed;
    logic [LED_W-1:0] led_reg;
    logic             point_reg;

    t_result due_outputs [$];
    t_result oldest;
    int      mismatches  = 0;
    int      beats_out   = 0;
    int      ticks_sent  = 0;
    int      idle_cycles = 0;
    bit      steady      = 1'b0;

    joystick_combination_lock DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_x_sample      (i_x_sample),
        .i_y_sample      (i_y_sample),
        .i_button_pin    (i_button_pin),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_segments      (o_segments),
        .o_led_value     (o_led_value),
        .o_decimal_point (o_decimal_point),
        .o_action        (o_action),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic lock_reset();
        int i;
        thr_high        = RST_DIRECTION_HIGH;
        thr_low         = RST_DIRECTION_LOW;
        win_min         = RST_CENTER_MIN;
        win_max         = RST_CENTER_MAX;
        lock_mode       = LOCK_WAIT;
        entry_pos       = '0;
        last_sym        = SYM_NONE;
        unlock_odd      = 1'b0;
        overwrite_armed = 1'b0;
        led_reg         = '0;
        point_reg       = 1'b0;
        for (i = 0; i < CODE_LENGTH; i++) begin
            entered_syms[i] = SYM_NONE;
            code_syms[i]    = RESET_CODE[(i % 4)*SYM_W +: SYM_W];
        end
    endtask

    // one tick of the lock: classify, step the mode machine, update the display
    function automatic t_result lock_tick(t_sample x, t_sample y, logic btn);
        t_result r;
        logic    centered;
        logic    completed;
        logic    matched;
        int      pos;
        int      i;
        centered  = x >= win_min && x <= win_max && y >= win_min && y <= win_max;
        completed = 1'b0;
        r.action  = ACT_NONE;
        if (y >= thr_high) begin
            r.seg = SEG_YHIGH;
            last_sym = SYM_RIGHT;
        end else if (y <= thr_low) begin
            r.seg = SEG_YLOW;
            last_sym = SYM_LEFT;
        end else if (x >= thr_high) begin
            r.seg = SEG_XHIGH;
            last_sym = SYM_UP;
        end else if (x <= thr_low) begin
            r.seg = SEG_XLOW;
            last_sym = SYM_DOWN;
        end else begin
            r.seg = SEG_CENTER;
        end
        case (lock_mode)
            LOCK_WAIT: begin
                if (!centered)
                    lock_mode = LOCK_PRESS;
                else if (btn == BTN_PRESSED && unlock_odd)
                    lock_mode = LOCK_OVERWRITE;
            end
            LOCK_OVERWRITE: begin
                if (btn == BTN_RELEASED)
                    lock_mode = LOCK_WAIT;
            end
            LOCK_PRESS: if (centered) begin
                pos = entry_pos;
                entered_syms[pos] = last_sym;
                if (overwrite_armed)
                    code_syms[pos] = last_sym;
                if (pos == CODE_LENGTH - 1) begin
                    entry_pos = '0;
                    r.seg     = SEG_CENTER;
                    matched   = 1'b1;
                    for (i = 0; i < CODE_LENGTH; i++)
                        if (entered_syms[i] != code_syms[i])
                            matched = 1'b0;
                    if (matched) begin
                        unlock_odd      = !unlock_odd;
                        overwrite_armed = 1'b0;
                        point_reg       = 1'b0;
                        r.action        = unlock_odd ? ACT_CW : ACT_CCW;
                    end else begin
                        r.action = ACT_BLINK;
                        led_reg  = '1;
                    end
                    completed = 1'b1;
                end else begin
                    entry_pos = POS_W'(pos + 1);
                end
                lock_mode = LOCK_WAIT;
            end
            default: lock_mode = LOCK_WAIT;
        endcase
        // a finished code leaves the leds as the compare set them
        if (!completed) begin
            if (lock_mode == LOCK_WAIT) begin
                led_reg = LED_W'(entry_pos);
            end else if (lock_mode == LOCK_OVERWRITE) begin
                entry_pos       = '0;
                overwrite_armed = 1'b1;
                point_reg       = 1'b1;
            end
        end
        r.led   = led_reg;
        r.point = point_reg;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch in %s at result beat %0d: expected %0d, got %0d",
                     what, beats_out, want, got);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_outputs.size() == 0) begin
                report("beat with nothing pending", 0, 0);
            end else begin
                oldest = due_outputs.pop_front();
                if (o_segments !== oldest.seg)
                    report("segments", 32'(oldest.seg), 32'(o_segments));
                if (o_led_value !== oldest.led)
                    report("led_value", 32'(oldest.led), 32'(o_led_value));
                if (o_decimal_point !== oldest.point)
                    report("decimal_point", 32'(oldest.point), 32'(o_decimal_point));
                if (o_action !== oldest.action)
                    report("action", 32'(oldest.action), 32'(o_action));
            end
            beats_out++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[joystick_combination_lock] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ready is stable at the falling edge, so the beat goes at the next rising one
    task automatic send_tick(t_sample x, t_sample y, logic btn);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_x_sample   <= x;
        i_y_sample   <= y;
        i_button_pin <= btn;
        i_in_valid   <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (o_in_ready)
                break;
        end
        @(posedge i_clk);
        due_outputs.push_back(lock_tick(x, y, btn));
        ticks_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_sample val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready)
                break;
        end
        @(posedge i_clk);
        case (idx)
            CFG_DIRECTION_HIGH: thr_high = val;
            CFG_DIRECTION_LOW:  thr_low  = val;
            CFG_CENTER_MIN:     win_min  = val;
            CFG_CENTER_MAX:     win_max  = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // uniform in [lo, hi] clipped to the sample range, anything when empty
    function automatic t_sample pick(int lo, int hi);
        if (lo < 0)
            lo = 0;
        if (hi > SAMPLE_TOP)
            hi = SAMPLE_TOP;
        if (lo > hi)
            return t_sample'($urandom);
        return t_sample'($urandom_range(hi, lo));
    endfunction

    function automatic t_sample noise_sample();
        case ($urandom_range(10))
            0: return '0;
            1: return SAMPLE_MAX;
            2: return thr_high;
            3: return thr_high - 1'b1;
            4: return thr_low;
            5: return thr_low + 1'b1;
            6: return win_min;
            7: return win_min - 1'b1;
            8: return win_max;
            9: return win_max + 1'b1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    // deflection that leaves the center window and classifies as s
    task automatic deflect(t_sym s);
        t_sample x;
        t_sample y;
        int      hi_from;
        int      lo_to;
        hi_from = (int'(thr_high) > int'(win_max)) ? int'(thr_high) : int'(win_max) + 1;
        lo_to   = (int'(thr_low) < int'(win_min)) ? int'(thr_low) : int'(win_min) - 1;
        x = t_sample'($urandom);
        y = pick(int'(thr_low) + 1, int'(thr_high) - 1);
        case (s)
            SYM_RIGHT: y = pick(hi_from, SAMPLE_TOP);
            SYM_LEFT:  y = pick(0, lo_to);
            SYM_UP:    x = pick(hi_from, SAMPLE_TOP);
            default:   x = pick(0, lo_to);
        endcase
        send_tick(x, y, 1'($urandom_range(1)));
    endtask

    task automatic center_tick(logic btn);
        int lo;
        int hi;
        lo = (int'(thr_low) + 1 > int'(win_min)) ? int'(thr_low) + 1 : int'(win_min);
        hi = (int'(thr_high) - 1 < int'(win_max)) ? int'(thr_high) - 1 : int'(win_max);
        send_tick(pick(lo, hi), pick(lo, hi), btn);
    endtask

    // symbols until the entry wraps, either the stored code or random ones
    task automatic enter_code(bit follow_code);
        t_sym s;
        int   n;
        for (n = 0; n < CODE_LENGTH + 2; n++) begin
            s = follow_code ? code_syms[entry_pos]
                            : t_sym'($urandom_range(SYM_RIGHT, SYM_UP));
            deflect(s);
            if ($urandom_range(3) == 0)
                deflect(s);
            center_tick($urandom_range(9) != 0);
            if (entry_pos == 0)
                break;
        end
    endtask

    task automatic press_and_center(t_sample x, t_sample y);
        send_tick(x, y, BTN_RELEASED);
        send_tick(MID, MID, BTN_RELEASED);
    endtask

    task automatic test_directed();
        // button pressed with an even unlock count does not arm overwrite
        send_tick(MID, MID, BTN_PRESSED);
        // reset code up, down, left, right; the y axis wins over x
        press_and_center(SAMPLE_MAX, MID);
        press_and_center('0, MID);
        press_and_center(SAMPLE_MAX, '0);
        press_and_center('0, SAMPLE_MAX);
        // odd unlock count: holding the button arms overwrite
        send_tick(MID, MID, BTN_PRESSED);
        send_tick(MID, MID, BTN_RELEASED);
        press_and_center(MID, SAMPLE_MAX);
        press_and_center(MID, SAMPLE_MAX);
        press_and_center(MID, '0);
        press_and_center(SAMPLE_MAX, MID);
        // the old code no longer opens
        press_and_center(SAMPLE_MAX, MID);
        press_and_center('0, MID);
        press_and_center('0, '0);
        press_and_center(SAMPLE_MAX, SAMPLE_MAX);
    endtask

    task automatic threshold_phase(t_sample high, t_sample low, t_sample cmin, t_sample cmax);
        hold_until_drained();
        write_reg(CFG_DIRECTION_HIGH, high);
        write_reg(CFG_DIRECTION_LOW, low);
        write_reg(CFG_CENTER_MIN, cmin);
        write_reg(CFG_CENTER_MAX, cmax);
        // an index past the last register is dropped
        write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_CENTER_MAX + 1)),
                  t_sample'($urandom));
        repeat (20) send_tick(noise_sample(), noise_sample(), 1'($urandom_range(1)));
        enter_code(1'b1);
    endtask

    task automatic test_thresholds();
        threshold_phase('1, '0, '0, '1);
        threshold_phase('0, '1, '1, '0);
        threshold_phase('0, '0, '0, '0);
        threshold_phase('1, '1, '1, '1);
        repeat (2)
            threshold_phase(t_sample'($urandom), t_sample'($urandom),
                            t_sample'($urandom), t_sample'($urandom));
        threshold_phase(RST_DIRECTION_HIGH, RST_DIRECTION_LOW, RST_CENTER_MIN, RST_CENTER_MAX);
    endtask

    task automatic test_random_entry(int count);
        int start;
        int kind;
        int k;
        start = ticks_sent;
        while (ticks_sent < start + count) begin
            steady = (ticks_sent >= start + 300) && (ticks_sent < start + 500);
            kind = $urandom_range(99);
            if (kind < 50) begin
                enter_code(1'($urandom_range(1)));
            end else if (kind < 62) begin
                repeat ($urandom_range(3, 1)) center_tick(BTN_PRESSED);
                center_tick(BTN_RELEASED);
                enter_code(1'b0);
            end else if (kind < 75) begin
                repeat ($urandom_range(6, 1))
                    send_tick(noise_sample(), noise_sample(), 1'($urandom_range(1)));
            end else if (kind < 96) begin
                k = $urandom_range(2);
                if (k == 0) begin
                    // deflection with no return to center
                    repeat ($urandom_range(3, 1))
                        deflect(t_sym'($urandom_range(SYM_RIGHT, SYM_UP)));
                end else if (k == 1) begin
                    // inside the window yet past the low threshold
                    send_tick(pick(int'(win_min), int'(thr_low)), MID,
                              1'($urandom_range(1)));
                    send_tick(MID, pick(int'(win_min), int'(thr_low)),
                              1'($urandom_range(1)));
                end else begin
                    repeat ($urandom_range(4, 1)) center_tick(1'($urandom_range(1)));
                end
            end else begin
                hold_until_drained();
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_x_sample   <= '0;
        i_y_sample   <= '0;
        i_button_pin <= BTN_RELEASED;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_DIRECTION_HIGH;
        i_cfg_data   <= '0;
        lock_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_thresholds();
        test_random_entry(RANDOM_TICKS);
        hold_until_drained();
        if (mismatches == 0)
            $display("[joystick_combination_lock] OK");
        else
            $display("[joystick_combination_lock] ERROR");
        $finish;
    end

endmodule
